/* hdl/ssf_pkg.sv */
package ssf_pkg;

   // scanline geometry
   localparam int LINE_BYTES = 512;
   localparam int WORD_BYTES = 8;
   localparam int ROWS       = LINE_BYTES / WORD_BYTES;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int LANE_W     = $clog2(WORD_BYTES);
   localparam int BYTE_W     = $clog2(LINE_BYTES);
   localparam int WIDTH_W    = 10;
   localparam int WORD_W     = WORD_BYTES * 8;
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);

   // request kinds
   localparam logic [1:0] REQ_DRAW = 2'd0;
   localparam logic [1:0] REQ_READ = 2'd1;
   localparam logic [1:0] REQ_FILL = 2'd2;

   // draw modes
   localparam logic [1:0] MODE_SET    = 2'd0;
   localparam logic [1:0] MODE_CLEAR  = 2'd1;
   localparam logic [1:0] MODE_INVERT = 2'd2;

   // configuration register indexes
   localparam logic CSR_BACKGROUND = 1'b0;
   localparam logic CSR_ACTIVE     = 1'b1;

   // operation carried out by the back end
   typedef enum logic [1:0] {
      OP_NONE,
      OP_DRAW,
      OP_READ,
      OP_FILL
   } op_type;

   // classified command between front and back
   typedef struct packed {
      op_type            op;
      logic              status;
      logic [1:0]        mode;
      logic [BYTE_W-1:0] lo_byte;
      logic [BYTE_W-1:0] hi_byte;
      logic [7:0]        first_mask;
      logic [7:0]        last_mask;
      logic [7:0]        fill_byte;
   } cmd_type;

endpackage

/* hdl/scanline_span_fill.sv */
// Monochrome scanline span fill: one 512-byte line of 1-bit pixels, MSB leftmost.
// Request channel (req_*): draw a span, read one byte or fill the active line
// with the background byte. Response channel (rsp_*): one response per request,
// carrying the byte read (zero for other kinds) and an out-of-width flag.
// Configuration (csr_*): index 0 background byte, index 1 active width in bytes;
// write only while no request is outstanding.
// The line is held as 64 words of 8 bytes. Each request is classified on entry
// and queued (two deep); the back end walks the touched words with one read and
// one write port, one word per cycle. From the queue head a request goes through
// idle, a run over its words, drain and done; flagged requests go from idle
// straight to done. The word walk sets the rate while the receiver keeps up.
// Reset empties the queue and response register and the whole line reads as
// zero at once; no clearing pass is needed. When the receiver stalls, the
// finished response waits in its register, the back end goes on with the next
// request and holds in done, and the queue keeps taking requests until full.
module scanline_span_fill (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // span_start[11:0], span_end[23:12], draw_mode[25:24],
                                     // read_index[34:26], zero fill
   input  logic [1:0]   req_tuser,   // req_type[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // read_data[7:0]
   output logic [0:0]   rsp_tuser,   // status[0]
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [9:0]   csr_wdata
);

   logic [7:0]                   background_ff;
   logic [ssf_pkg::WIDTH_W-1:0]  active_bytes_ff;

   logic                         q_full;
   logic                         q_push;
   ssf_pkg::cmd_type             q_push_cmd;
   logic                         q_pop;
   logic                         q_valid;
   ssf_pkg::cmd_type             q_head_cmd;
   logic                         rsp_status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         background_ff   <= 8'h00;
         active_bytes_ff <= ssf_pkg::WIDTH_W'(ssf_pkg::LINE_BYTES);
      end else if (csr_we) begin
         case (csr_index)
            ssf_pkg::CSR_BACKGROUND: background_ff   <= csr_wdata[7:0];
            ssf_pkg::CSR_ACTIVE:     active_bytes_ff <= csr_wdata[ssf_pkg::WIDTH_W-1:0];
            default:                 background_ff   <= background_ff;
         endcase
      end
   end

   ssf_front u_front (
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_type        (req_tuser),
      .span_start      (req_tdata[11:0]),
      .span_end        (req_tdata[23:12]),
      .draw_mode       (req_tdata[25:24]),
      .read_index      (req_tdata[34:26]),
      .background_byte (background_ff),
      .active_bytes    (active_bytes_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (q_push_cmd)
   );

   ssf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head_cmd)
   );

   ssf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .read_data  (rsp_tdata),
      .status     (rsp_status)
   );

   assign rsp_tuser = rsp_status;

endmodule

/* hdl/ssf_front.sv */
module ssf_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [1:0]                    req_type,
   input  logic [11:0]                   span_start,
   input  logic [11:0]                   span_end,
   input  logic [1:0]                    draw_mode,
   input  logic [8:0]                    read_index,
   input  logic [7:0]                    background_byte,
   input  logic [ssf_pkg::WIDTH_W-1:0]   active_bytes,
   input  logic                          q_full,
   output logic                          q_push,
   output ssf_pkg::cmd_type              q_cmd
);

   logic [11:0]                 lo_col;
   logic [11:0]                 hi_col;
   logic [ssf_pkg::WIDTH_W-1:0] eff_width;
   logic [ssf_pkg::WIDTH_W-1:0] eff_last;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // order the span ends and clamp the active width
   always_comb begin
      if (span_start > span_end) begin
         lo_col = span_end;
         hi_col = span_start;
      end else begin
         lo_col = span_start;
         hi_col = span_end;
      end
      if (active_bytes > ssf_pkg::WIDTH_W'(ssf_pkg::LINE_BYTES)) begin
         eff_width = ssf_pkg::WIDTH_W'(ssf_pkg::LINE_BYTES);
      end else begin
         eff_width = active_bytes;
      end
      eff_last = eff_width - ssf_pkg::WIDTH_W'(1);
   end

   // classify the request into a back end command
   always_comb begin
      q_cmd            = '0;
      q_cmd.op         = ssf_pkg::OP_NONE;
      q_cmd.mode       = draw_mode;
      q_cmd.fill_byte  = background_byte;
      q_cmd.first_mask = 8'hFF;
      q_cmd.last_mask  = 8'hFF;
      case (req_type)
         ssf_pkg::REQ_DRAW: begin
            q_cmd.lo_byte    = lo_col[11:3];
            q_cmd.hi_byte    = hi_col[11:3];
            q_cmd.first_mask = 8'hFF >> lo_col[2:0];
            q_cmd.last_mask  = 8'hFF << (3'd7 - hi_col[2:0]);
            if ({1'b0, hi_col[11:3]} >= eff_width) begin
               q_cmd.status = 1'b1;
            end else if (draw_mode == ssf_pkg::MODE_SET || draw_mode == ssf_pkg::MODE_CLEAR
                         || draw_mode == ssf_pkg::MODE_INVERT) begin
               q_cmd.op = ssf_pkg::OP_DRAW;
            end
         end
         ssf_pkg::REQ_READ: begin
            q_cmd.lo_byte = read_index;
            q_cmd.hi_byte = read_index;
            if ({1'b0, read_index} < eff_width) begin
               q_cmd.op = ssf_pkg::OP_READ;
            end else begin
               q_cmd.status = 1'b1;
            end
         end
         ssf_pkg::REQ_FILL: begin
            q_cmd.lo_byte = '0;
            q_cmd.hi_byte = eff_last[ssf_pkg::BYTE_W-1:0];
            if (eff_width != '0) begin
               q_cmd.op = ssf_pkg::OP_FILL;
            end
         end
         default: begin
            q_cmd.op = ssf_pkg::OP_NONE;
         end
      endcase
   end

endmodule

/* hdl/ssf_queue.sv */
module ssf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ssf_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output ssf_pkg::cmd_type  head_cmd
);

   ssf_pkg::cmd_type            entry_ff [ssf_pkg::QDEPTH];
   logic [ssf_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ssf_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [ssf_pkg::QCNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == ssf_pkg::QCNT_W'(ssf_pkg::QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + ssf_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + ssf_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + ssf_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - ssf_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hdl/ssf_back.sv */
module ssf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  ssf_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        read_data,
   output logic              status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type                        state_ff, state_in;
   ssf_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [ssf_pkg::ROW_W-1:0]        row_ff, row_in;
   logic                             wr_pend_ff, wr_pend_in;
   logic [ssf_pkg::ROW_W-1:0]        wr_row_ff, wr_row_in;
   logic [7:0]                       rd_byte_ff, rd_byte_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       rsp_data_ff, rsp_data_in;
   logic                             rsp_status_ff, rsp_status_in;

   logic [ssf_pkg::WORD_W-1:0]       mem_ff [ssf_pkg::ROWS];
   logic [ssf_pkg::WORD_W-1:0]       mem_q_ff;
   logic [ssf_pkg::ROWS-1:0]         row_valid_ff;
   logic                             rd_valid_ff;

   logic                             rd_en;
   logic [ssf_pkg::ROW_W-1:0]        hi_row;
   logic                             slot_free;
   logic [ssf_pkg::WORD_W-1:0]       old_word;
   logic [ssf_pkg::WORD_W-1:0]       new_word;
   logic                             wr_en;

   assign hi_row     = cmd_ff.hi_byte[ssf_pkg::BYTE_W-1:ssf_pkg::LANE_W];
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign rd_en      = (state_ff == S_RUN);
   assign rsp_tvalid = rsp_valid_ff;
   assign read_data  = rsp_data_ff;
   assign status     = rsp_status_ff;

   // rows never written read as zero
   assign old_word = rd_valid_ff ? mem_q_ff : '0;

   // per-byte mask and update of the word under modification
   always_comb begin
      logic [ssf_pkg::BYTE_W-1:0] baddr;
      logic [7:0]                 m;
      logic [7:0]                 ob;
      logic [7:0]                 nb;
      new_word = old_word;
      for (int k = 0; k < ssf_pkg::WORD_BYTES; k++) begin
         baddr = {wr_row_ff, ssf_pkg::LANE_W'(k)};
         ob    = old_word[8*k +: 8];
         m     = 8'h00;
         if (baddr >= cmd_ff.lo_byte && baddr <= cmd_ff.hi_byte) begin
            m = 8'hFF;
            if (baddr == cmd_ff.lo_byte) begin
               m = m & cmd_ff.first_mask;
            end
            if (baddr == cmd_ff.hi_byte) begin
               m = m & cmd_ff.last_mask;
            end
         end
         nb = ob;
         if (cmd_ff.op == ssf_pkg::OP_FILL) begin
            nb = (ob & ~m) | (cmd_ff.fill_byte & m);
         end else begin
            case (cmd_ff.mode)
               ssf_pkg::MODE_SET:    nb = ob | m;
               ssf_pkg::MODE_CLEAR:  nb = ob & ~m;
               ssf_pkg::MODE_INVERT: nb = ob ^ m;
               default:              nb = ob;
            endcase
         end
         new_word[8*k +: 8] = nb;
      end
   end

   assign wr_en = wr_pend_ff
                  && (cmd_ff.op == ssf_pkg::OP_DRAW || cmd_ff.op == ssf_pkg::OP_FILL);

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      row_in        = row_ff;
      wr_pend_in    = 1'b0;
      wr_row_in     = wr_row_ff;
      rd_byte_in    = rd_byte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cmd_in = q_cmd;
               row_in = q_cmd.lo_byte[ssf_pkg::BYTE_W-1:ssf_pkg::LANE_W];
               if (q_cmd.op == ssf_pkg::OP_NONE) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            wr_pend_in = 1'b1;
            wr_row_in  = row_ff;
            if (row_ff == hi_row) begin
               state_in = S_DRAIN;
            end else begin
               row_in = row_ff + ssf_pkg::ROW_W'(1);
            end
         end
         S_DRAIN: begin
            rd_byte_in = old_word[8*cmd_ff.lo_byte[ssf_pkg::LANE_W-1:0] +: 8];
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = (cmd_ff.op == ssf_pkg::OP_READ) ? rd_byte_ff : 8'h00;
               rsp_status_in = cmd_ff.status;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      wr_row_ff     <= wr_row_in;
      rd_byte_ff    <= rd_byte_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // line store, one read and one write port, rows marked valid once written
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff    <= mem_ff[row_ff];
         rd_valid_ff <= row_valid_ff[row_ff];
      end
      if (wr_en) begin
         mem_ff[wr_row_ff] <= new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_row_ff] <= 1'b1;
      end
   end

endmodule
